// ----- rtl/core/ufr_pkg.sv -----
// shared types and constants of the union-find unit
`default_nettype none

package ufr_pkg;

    localparam int ELEM_W = 7;
    localparam int RANK_W = 3;

    localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;

    localparam logic ACT_FIND  = 1'b0;
    localparam logic ACT_UNION = 1'b1;

    typedef struct packed {
        logic [ELEM_W-1:0] root;
        logic              merged;
        logic [RANK_W-1:0] root_rank;
    } t_rsp;

    typedef struct packed {
        logic parent_we;
        logic rank_we;
    } t_mem_we;

endpackage

`default_nettype wire

// ----- rtl/core/ufr_if.sv -----
// request and response channel interfaces of the union-find unit
`default_nettype none

interface ufr_req_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [6:0] elem_a;
    logic [6:0] elem_b;

    modport source(output valid, output action, output elem_a, output elem_b, input ready);
    modport sink(input valid, input action, input elem_a, input elem_b, output ready);
endinterface

interface ufr_rsp_if;
    logic       valid;
    logic       ready;
    logic [6:0] root;
    logic       merged;
    logic [2:0] root_rank;

    modport source(output valid, output root, output merged, output root_rank, input ready);
    modport sink(input valid, input root, input merged, input root_rank, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/union_find_rank_path_compression_unit.sv -----
// Disjoint-set unit with union by rank and full path compression over
// NUM_ELEMENTS elements. After reset a clearing pass over all elements
// sets every element to be its own root with rank 0; no item is taken during
// it. Items are then handled one at a time by a sequencer around the parent
// and rank memories, each with one write and one registered read port. A find
// walks the path from elem_a to its root and again to compress it; a union
// does so from elem_a and then elem_b, and links two distinct roots by rank.
// Indexes at or above NUM_ELEMENTS are wrapped by repeated subtraction. The
// result sits in an output register, so the next item is accepted while it waits.
`default_nettype none

module union_find_rank_path_compression_unit #(
    parameter int NUM_ELEMENTS = 128
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ufr_req_if.sink   i_req,
    ufr_rsp_if.source o_rsp
);

    localparam int IW = $clog2(NUM_ELEMENTS);

    logic                       w_idle;
    logic                       w_res_valid;
    ufr_pkg::t_rsp              w_res;
    logic                       w_out_busy;
    logic [IW-1:0]              w_rd_addr;
    ufr_pkg::t_mem_we           w_we;
    logic [IW-1:0]              w_parent_waddr;
    logic [IW-1:0]              w_parent_wdata;
    logic [IW-1:0]              w_rank_waddr;
    logic [ufr_pkg::RANK_W-1:0] w_rank_wdata;
    logic [IW-1:0]              w_parent_rdata;
    logic [ufr_pkg::RANK_W-1:0] w_rank_rdata;

    logic                       r_out_valid;
    ufr_pkg::t_rsp              r_out;

    assign i_req.ready     = w_idle;
    assign w_out_busy      = r_out_valid && !o_rsp.ready;
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.root      = r_out.root;
    assign o_rsp.merged    = r_out.merged;
    assign o_rsp.root_rank = r_out.root_rank;

    ufr_seq #(
        .NUM_ELEMENTS(NUM_ELEMENTS)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_req.valid && w_idle),
        .i_action       (i_req.action),
        .i_elem_a       (i_req.elem_a),
        .i_elem_b       (i_req.elem_b),
        .i_out_busy     (w_out_busy),
        .o_idle         (w_idle),
        .o_res_valid    (w_res_valid),
        .o_res          (w_res),
        .o_rd_addr      (w_rd_addr),
        .o_we           (w_we),
        .o_parent_waddr (w_parent_waddr),
        .o_parent_wdata (w_parent_wdata),
        .o_rank_waddr   (w_rank_waddr),
        .o_rank_wdata   (w_rank_wdata),
        .i_parent_rdata (w_parent_rdata),
        .i_rank_rdata   (w_rank_rdata)
    );

    ufr_table #(
        .NUM_ELEMENTS(NUM_ELEMENTS)
    ) u_table (
        .i_clk          (i_clk),
        .i_rd_addr      (w_rd_addr),
        .i_we           (w_we),
        .i_parent_waddr (w_parent_waddr),
        .i_parent_wdata (w_parent_wdata),
        .i_rank_waddr   (w_rank_waddr),
        .i_rank_wdata   (w_rank_wdata),
        .o_parent_rdata (w_parent_rdata),
        .o_rank_rdata   (w_rank_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
            r_out       <= w_res;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ufr_table.sv -----
// parent link and rank memories, one write and one registered read port each
`default_nettype none

module ufr_table #(
    parameter int NUM_ELEMENTS = 128
) (
    input  wire logic                              i_clk,
    input  wire logic [$clog2(NUM_ELEMENTS)-1:0]   i_rd_addr,
    input  wire ufr_pkg::t_mem_we                  i_we,
    input  wire logic [$clog2(NUM_ELEMENTS)-1:0]   i_parent_waddr,
    input  wire logic [$clog2(NUM_ELEMENTS)-1:0]   i_parent_wdata,
    input  wire logic [$clog2(NUM_ELEMENTS)-1:0]   i_rank_waddr,
    input  wire logic [ufr_pkg::RANK_W-1:0]        i_rank_wdata,
    output logic      [$clog2(NUM_ELEMENTS)-1:0]   o_parent_rdata,
    output logic      [ufr_pkg::RANK_W-1:0]        o_rank_rdata
);

    localparam int IW = $clog2(NUM_ELEMENTS);

    logic [IW-1:0]              r_parent_mem [NUM_ELEMENTS];
    logic [ufr_pkg::RANK_W-1:0] r_rank_mem   [NUM_ELEMENTS];

    always_ff @(posedge i_clk) begin
        if (i_we.parent_we) begin
            r_parent_mem[i_parent_waddr] <= i_parent_wdata;
        end
        if (i_we.rank_we) begin
            r_rank_mem[i_rank_waddr] <= i_rank_wdata;
        end
        o_parent_rdata <= r_parent_mem[i_rd_addr];
        o_rank_rdata   <= r_rank_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/ufr_seq.sv -----
// sequencer: index wrap, two-pass root walk, rank compare and link
`default_nettype none

module ufr_seq #(
    parameter int NUM_ELEMENTS = 128
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic                              i_action,
    input  wire logic [ufr_pkg::ELEM_W-1:0]        i_elem_a,
    input  wire logic [ufr_pkg::ELEM_W-1:0]        i_elem_b,
    input  wire logic                              i_out_busy,
    output logic                                   o_idle,
    output logic                                   o_res_valid,
    output ufr_pkg::t_rsp                          o_res,
    output logic      [$clog2(NUM_ELEMENTS)-1:0]   o_rd_addr,
    output ufr_pkg::t_mem_we                       o_we,
    output logic      [$clog2(NUM_ELEMENTS)-1:0]   o_parent_waddr,
    output logic      [$clog2(NUM_ELEMENTS)-1:0]   o_parent_wdata,
    output logic      [$clog2(NUM_ELEMENTS)-1:0]   o_rank_waddr,
    output logic      [ufr_pkg::RANK_W-1:0]        o_rank_wdata,
    input  wire logic [$clog2(NUM_ELEMENTS)-1:0]   i_parent_rdata,
    input  wire logic [ufr_pkg::RANK_W-1:0]        i_rank_rdata
);

    localparam int IW = $clog2(NUM_ELEMENTS);
    localparam int RW = (IW > ufr_pkg::ELEM_W) ? IW : ufr_pkg::ELEM_W;
    localparam int CW = RW + 1;
    localparam logic [CW-1:0] N_C      = CW'(NUM_ELEMENTS);
    localparam logic [IW:0]   N_S      = (IW + 1)'(NUM_ELEMENTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_ELEMENTS - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WRAP,
        S_W1_RD,
        S_W1_CHK,
        S_W2_RD,
        S_W2_WR,
        S_RKA_RD,
        S_RKA_CHK,
        S_RKB_RD,
        S_RKB_CHK,
        S_LINK,
        S_DONE
    } t_state;

    t_state                     r_state;
    logic                       r_act;
    logic [CW-1:0]              r_a;
    logic [CW-1:0]              r_b;
    logic [IW-1:0]              r_node;
    logic [IW-1:0]              r_start;
    logic [IW-1:0]              r_top;
    logic [IW-1:0]              r_ra;
    logic                       r_second;
    logic [IW:0]                r_steps;
    logic [ufr_pkg::RANK_W-1:0] r_rank_a;
    logic [ufr_pkg::RANK_W-1:0] r_rank_b;
    logic [IW-1:0]              r_res_root;
    logic                       r_res_merged;
    logic [ufr_pkg::RANK_W-1:0] r_res_rank;
    logic                       r_res_valid;

    logic                       w_a_hi;
    logic                       w_b_hi;
    logic [CW-1:0]              w_sub_out;
    logic [IW:0]                w_steps_inc;
    logic [ufr_pkg::RANK_W-1:0] w_rank_inc;
    logic [RW-1:0]              w_root_ext;

    // compares and a shared subtract for the index wrap
    assign w_a_hi      = (r_a >= N_C);
    assign w_b_hi      = (r_b >= N_C);
    assign w_sub_out   = (w_a_hi ? r_a : r_b) - N_C;
    assign w_steps_inc = r_steps + (IW + 1)'(1);
    assign w_rank_inc  = (r_rank_a == ufr_pkg::RANK_MAX) ? ufr_pkg::RANK_MAX
                                                          : r_rank_a + 3'd1;
    assign w_root_ext  = RW'(r_res_root);

    assign o_idle              = (r_state == S_IDLE);
    assign o_res_valid         = r_res_valid;
    assign o_res.root          = w_root_ext[ufr_pkg::ELEM_W-1:0];
    assign o_res.merged        = r_res_merged;
    assign o_res.root_rank     = r_res_rank;
    assign o_rd_addr           = r_node;

    always_comb begin
        o_we.parent_we = 1'b0;
        o_we.rank_we   = 1'b0;
        o_parent_waddr = r_node;
        o_parent_wdata = r_top;
        o_rank_waddr   = r_ra;
        o_rank_wdata   = w_rank_inc;
        unique case (r_state)
            S_CLEAR: begin
                o_we.parent_we = 1'b1;
                o_we.rank_we   = 1'b1;
                o_parent_waddr = r_steps[IW-1:0];
                o_parent_wdata = r_steps[IW-1:0];
                o_rank_waddr   = r_steps[IW-1:0];
                o_rank_wdata   = '0;
            end
            S_W2_WR: begin
                o_we.parent_we = 1'b1;
            end
            S_LINK: begin
                o_we.parent_we = 1'b1;
                if (r_rank_a < r_rank_b) begin
                    o_parent_waddr = r_ra;
                    o_parent_wdata = r_top;
                end else begin
                    o_parent_waddr = r_top;
                    o_parent_wdata = r_ra;
                end
                o_we.rank_we = (r_rank_a == r_rank_b);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_steps     <= '0;
            r_second    <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    if (r_steps[IW-1:0] == LAST_IDX) begin
                        r_state <= S_IDLE;
                    end
                    r_steps <= w_steps_inc;
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_act   <= i_action;
                        r_a     <= CW'(i_elem_a);
                        r_b     <= CW'(i_elem_b);
                        r_state <= S_WRAP;
                    end
                end
                S_WRAP: begin
                    if (w_a_hi) begin
                        r_a <= w_sub_out;
                    end else if (w_b_hi) begin
                        r_b <= w_sub_out;
                    end else begin
                        r_node   <= r_a[IW-1:0];
                        r_start  <= r_a[IW-1:0];
                        r_second <= 1'b0;
                        r_steps  <= '0;
                        r_state  <= S_W1_RD;
                    end
                end
                S_W1_RD: begin
                    r_state <= S_W1_CHK;
                end
                S_W1_CHK: begin
                    if (i_parent_rdata == r_node) begin
                        r_top   <= r_node;
                        r_node  <= r_start;
                        r_steps <= '0;
                        r_state <= S_W2_RD;
                    end else if (w_steps_inc == N_S) begin
                        // chain without a root: last element reached stands in
                        r_top   <= i_parent_rdata;
                        r_node  <= r_start;
                        r_steps <= '0;
                        r_state <= S_W2_RD;
                    end else begin
                        r_node  <= i_parent_rdata;
                        r_steps <= w_steps_inc;
                        r_state <= S_W1_RD;
                    end
                end
                S_W2_RD: begin
                    if (r_node == r_top || r_steps == N_S) begin
                        if (!r_second) begin
                            r_ra <= r_top;
                            if (r_act == ufr_pkg::ACT_UNION) begin
                                r_second <= 1'b1;
                                r_node   <= r_b[IW-1:0];
                                r_start  <= r_b[IW-1:0];
                                r_steps  <= '0;
                                r_state  <= S_W1_RD;
                            end else begin
                                r_node  <= r_top;
                                r_state <= S_RKA_RD;
                            end
                        end else begin
                            r_node  <= r_ra;
                            r_state <= S_RKA_RD;
                        end
                    end else begin
                        r_state <= S_W2_WR;
                    end
                end
                S_W2_WR: begin
                    r_node  <= i_parent_rdata;
                    r_steps <= w_steps_inc;
                    r_state <= S_W2_RD;
                end
                S_RKA_RD: begin
                    r_state <= S_RKA_CHK;
                end
                S_RKA_CHK: begin
                    r_rank_a <= i_rank_rdata;
                    if (r_act == ufr_pkg::ACT_FIND || r_ra == r_top) begin
                        r_res_root   <= r_ra;
                        r_res_merged <= 1'b0;
                        r_res_rank   <= i_rank_rdata;
                        r_state      <= S_DONE;
                    end else begin
                        r_node  <= r_top;
                        r_state <= S_RKB_RD;
                    end
                end
                S_RKB_RD: begin
                    r_state <= S_RKB_CHK;
                end
                S_RKB_CHK: begin
                    r_rank_b <= i_rank_rdata;
                    r_state  <= S_LINK;
                end
                S_LINK: begin
                    r_res_merged <= 1'b1;
                    if (r_rank_a < r_rank_b) begin
                        r_res_root <= r_top;
                        r_res_rank <= r_rank_b;
                    end else if (r_rank_b < r_rank_a) begin
                        r_res_root <= r_ra;
                        r_res_rank <= r_rank_a;
                    end else begin
                        r_res_root <= r_ra;
                        r_res_rank <= w_rank_inc;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!i_out_busy) begin
                        r_res_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ufr_checker.sv -----
// port-level assertions of the union-find unit and their binding
`default_nettype none

module ufr_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_req_valid,
    input wire logic       i_req_ready,
    input wire logic       i_rsp_valid,
    input wire logic       i_rsp_ready,
    input wire logic [6:0] i_rsp_root,
    input wire logic       i_rsp_merged,
    input wire logic [2:0] i_rsp_root_rank
);

    // a stalled item stays offered
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped while stalled");

    // one item at a time
    a_req_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while busy");

    // a merge leaves a root of rank one or more
    a_merge_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_merged |-> i_rsp_root_rank != 3'd0)
        else $error("merged root with rank zero");

    // no result rises too soon after an accept
    a_rsp_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> ##1 !$rose(i_rsp_valid))
        else $error("result too soon after accept");

    // result fields hold while stalled
    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            $stable(i_rsp_root) && $stable(i_rsp_merged) && $stable(i_rsp_root_rank))
        else $error("response payload changed while stalled");

endmodule

bind union_find_rank_path_compression_unit ufr_checker u_ufr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_rsp_root      (o_rsp.root),
    .i_rsp_merged    (o_rsp.merged),
    .i_rsp_root_rank (o_rsp.root_rank)
);

`default_nettype wire

// ----- tb/sv/union_find_rank_path_compression_unit_tb.sv -----
// self-checking testbench of the union-find unit: directed and random finds and unions
`timescale 1ns / 100ps

module union_find_rank_path_compression_unit_tb;

    localparam int NUM_ELEM   = 128;
    localparam int GROUP_SIZE = 16;
    localparam int GROUP_OPS  = 200;
    localparam int TAIL_OPS   = 150;

    typedef logic [ufr_pkg::ELEM_W-1:0] t_elem;

    typedef struct packed {
        logic  action;
        t_elem elem_a;
        t_elem elem_b;
    } t_uf_op;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ufr_req_if req_ch();
    ufr_rsp_if rsp_ch();

    union_find_rank_path_compression_unit #(
        .NUM_ELEMENTS(NUM_ELEM)
    ) dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_req(req_ch),
        .o_rsp(rsp_ch)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // local copy of the disjoint-set table
    t_elem                      set_parent [NUM_ELEM];
    logic [ufr_pkg::RANK_W-1:0] set_rank   [NUM_ELEM];

    t_uf_op        pending_ops[$];
    ufr_pkg::t_rsp expected_rsps[$];
    t_uf_op        op_on_bus;
    ufr_pkg::t_rsp want_rsp;
    int     mismatch_count = 0;
    int     total_ops = 0;
    int     results_seen = 0;
    int     req_gap_left;
    int     rsp_stall_left;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch %0d: %s", $realtime, mismatch_count, msg);
    endtask

    function automatic t_elem find_and_flatten(input t_elem start);
        t_elem node;
        t_elem top;
        t_elem up;
        int    steps;
        node  = start;
        steps = 0;
        while (steps < NUM_ELEM && set_parent[node] != node) begin
            node = set_parent[node];
            steps++;
        end
        top   = node;
        node  = start;
        steps = 0;
        while (steps < NUM_ELEM && node != top) begin
            up               = set_parent[node];
            set_parent[node] = top;
            node             = up;
            steps++;
        end
        return top;
    endfunction

    function automatic ufr_pkg::t_rsp apply_set_op(input t_uf_op op);
        ufr_pkg::t_rsp res;
        t_elem         ra;
        t_elem         rb;
        res.merged = 1'b0;
        if (op.action == ufr_pkg::ACT_FIND) begin
            res.root = find_and_flatten(op.elem_a);
        end else begin
            ra       = find_and_flatten(op.elem_a);
            rb       = find_and_flatten(op.elem_b);
            res.root = ra;
            if (ra != rb) begin
                res.merged = 1'b1;
                if (set_rank[ra] < set_rank[rb]) begin
                    set_parent[ra] = rb;
                    res.root       = rb;
                end else if (set_rank[rb] < set_rank[ra]) begin
                    set_parent[rb] = ra;
                end else begin
                    set_parent[rb] = ra;
                    if (set_rank[ra] != ufr_pkg::RANK_MAX) begin
                        set_rank[ra] = set_rank[ra] + 1'b1;
                    end
                end
            end
        end
        res.root_rank = set_rank[res.root];
        return res;
    endfunction

    function automatic void push_op(input logic act, input int a, input int b);
        t_uf_op op;
        op.action = act;
        op.elem_a = t_elem'(a);
        op.elem_b = t_elem'(b);
        pending_ops.push_back(op);
    endfunction

    function automatic bit req_idle_on();
        return pending_ops.size() > TAIL_OPS && ((pending_ops.size() / 96) % 4) != 0;
    endfunction

    function automatic bit rsp_idle_on();
        int left;
        left = total_ops - results_seen;
        return left > TAIL_OPS && ((left / 80) % 4) != 1;
    endfunction

    // request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            req_ch.valid  <= 1'b0;
            req_ch.action <= ufr_pkg::ACT_FIND;
            req_ch.elem_a <= '0;
            req_ch.elem_b <= '0;
            req_gap_left  <= 0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                expected_rsps.push_back(apply_set_op(op_on_bus));
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (req_gap_left > 0) begin
                    req_gap_left <= req_gap_left - 1;
                    req_ch.valid <= 1'b0;
                end else if (req_idle_on() && $urandom_range(0, 7) == 0) begin
                    req_gap_left <= $urandom_range(0, 12);
                    req_ch.valid <= 1'b0;
                end else if (pending_ops.size() > 0) begin
                    op_on_bus = pending_ops.pop_front();
                    req_ch.valid  <= 1'b1;
                    req_ch.action <= op_on_bus.action;
                    req_ch.elem_a <= op_on_bus.elem_a;
                    req_ch.elem_b <= op_on_bus.elem_b;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_ch.ready   <= 1'b0;
            rsp_stall_left <= 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                results_seen++;
                if (expected_rsps.size() == 0) begin
                    report_mismatch($sformatf("result with no item outstanding, root %0d",
                        rsp_ch.root));
                end else begin
                    want_rsp = expected_rsps.pop_front();
                    if (rsp_ch.root !== want_rsp.root) begin
                        report_mismatch($sformatf("root got %0d want %0d",
                            rsp_ch.root, want_rsp.root));
                    end
                    if (rsp_ch.merged !== want_rsp.merged) begin
                        report_mismatch($sformatf("merged got %0d want %0d",
                            rsp_ch.merged, want_rsp.merged));
                    end
                    if (rsp_ch.root_rank !== want_rsp.root_rank) begin
                        report_mismatch($sformatf("root_rank got %0d want %0d",
                            rsp_ch.root_rank, want_rsp.root_rank));
                    end
                end
            end
            if (rsp_stall_left > 0) begin
                rsp_stall_left <= rsp_stall_left - 1;
                rsp_ch.ready   <= 1'b0;
            end else if (rsp_idle_on() && $urandom_range(0, 7) == 0) begin
                rsp_stall_left <= $urandom_range(0, 12);
                rsp_ch.ready   <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int pick;
        int base;
        req_ch.valid  = 1'b0;
        req_ch.action = ufr_pkg::ACT_FIND;
        req_ch.elem_a = '0;
        req_ch.elem_b = '0;
        rsp_ch.ready  = 1'b0;
        for (int i = 0; i < NUM_ELEM; i++) begin
            set_parent[i] = t_elem'(i);
            set_rank[i]   = '0;
        end

        // directed: extremes, ties, rank ordering, same-set unions, compression
        push_op(ufr_pkg::ACT_FIND, 0, 127);
        push_op(ufr_pkg::ACT_FIND, 127, 0);
        push_op(ufr_pkg::ACT_UNION, 0, 127);
        push_op(ufr_pkg::ACT_UNION, 127, 0);
        push_op(ufr_pkg::ACT_UNION, 5, 5);
        push_op(ufr_pkg::ACT_UNION, 1, 2);
        push_op(ufr_pkg::ACT_UNION, 3, 1);
        push_op(ufr_pkg::ACT_UNION, 0, 1);
        push_op(ufr_pkg::ACT_FIND, 3, 85);
        push_op(ufr_pkg::ACT_FIND, 2, 42);
        push_op(ufr_pkg::ACT_UNION, 4, 0);
        push_op(ufr_pkg::ACT_UNION, 0, 6);
        push_op(ufr_pkg::ACT_FIND, 127, 127);
        push_op(ufr_pkg::ACT_UNION, 85, 42);
        push_op(ufr_pkg::ACT_UNION, 64, 63);
        push_op(ufr_pkg::ACT_UNION, 85, 64);
        push_op(ufr_pkg::ACT_FIND, 63, 0);
        push_op(ufr_pkg::ACT_UNION, 63, 127);
        push_op(ufr_pkg::ACT_FIND, 42, 127);
        push_op(ufr_pkg::ACT_UNION, 2, 85);
        push_op(ufr_pkg::ACT_FIND, 64, 1);

        // grouped random work so that trees grow and flatten in many places
        for (int g = 0; g < NUM_ELEM / GROUP_SIZE; g++) begin
            base = g * GROUP_SIZE;
            for (int k = 0; k < GROUP_OPS; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    push_op(ufr_pkg::ACT_FIND, $urandom_range(0, 127),
                        $urandom_range(0, 127));
                end else if (pick < 13) begin
                    push_op(ufr_pkg::ACT_UNION, $urandom_range(0, 127),
                        $urandom_range(0, 127));
                end else if (pick < 35) begin
                    push_op(ufr_pkg::ACT_UNION, base + $urandom_range(0, GROUP_SIZE - 1),
                        base + $urandom_range(0, GROUP_SIZE - 1));
                end else begin
                    push_op(ufr_pkg::ACT_FIND, base + $urandom_range(0, GROUP_SIZE - 1),
                        $urandom_range(0, 127));
                end
            end
        end

        // pairwise merging of the groups to push ranks up
        for (int step = GROUP_SIZE; step < NUM_ELEM; step = step * 2) begin
            for (int g = 0; g < NUM_ELEM; g = g + 2 * step) begin
                push_op(ufr_pkg::ACT_UNION, g + $urandom_range(0, GROUP_SIZE - 1),
                    g + step + $urandom_range(0, GROUP_SIZE - 1));
                push_op(ufr_pkg::ACT_FIND, g + step + $urandom_range(0, GROUP_SIZE - 1),
                    $urandom_range(0, 127));
            end
        end

        for (int k = 0; k < 120; k++) begin
            push_op(1'($urandom_range(0, 1)), $urandom_range(0, 127),
                $urandom_range(0, 127));
        end
        total_ops = pending_ops.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() > 0 || req_ch.valid || expected_rsps.size() > 0) begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);

        if (mismatch_count == 0 && expected_rsps.size() == 0) begin
            $display("union_find_rank_path_compression_unit regression: pass");
        end else begin
            $display("union_find_rank_path_compression_unit regression: fail");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("union_find_rank_path_compression_unit regression: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/ufr_pkg.sv
rtl/core/ufr_if.sv
rtl/core/ufr_table.sv
rtl/core/ufr_seq.sv
rtl/core/union_find_rank_path_compression_unit.sv
rtl/core/ufr_checker.sv
tb/sv/union_find_rank_path_compression_unit_tb.sv
